>>> sv/rpq_pkg.sv
// Package for the read-priority request queue block.
// Holds command and status codes, field widths, defaults and the address-table word.
// No dependencies.
`default_nettype none
package rpq_pkg;

   localparam int DEF_CAPACITY   = 64;
   localparam int DEF_NUM_QUEUES = 16;

   localparam int MODE_W   = 3;
   localparam int QID_W    = 4;
   localparam int ADDR_W   = 32;
   localparam int HANDLE_W = 32;
   localparam int SLOT_W   = 6;
   localparam int STATUS_W = 3;
   localparam int TAG_W    = 32;
   localparam int COUNT_W  = 7;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;
   localparam int QC_W       = 5;
   localparam int CL_W       = 7;

   localparam logic [CSR_IDX_W-1:0] CSR_QUEUE_COUNT    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY_LIMIT = 2'd1;
   localparam logic [QC_W-1:0]      QUEUE_COUNT_RESET  = 5'd16;
   localparam logic [CL_W-1:0]      CAP_LIMIT_RESET    = 7'd64;

   localparam logic [MODE_W-1:0] MODE_ENQUEUE = 3'd0;
   localparam logic [MODE_W-1:0] MODE_DEQUEUE = 3'd1;
   localparam logic [MODE_W-1:0] MODE_REMOVE  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_MOVE    = 3'd3;

   localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_BADQ    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NONE    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_BADSLOT = 3'd4;

   // one address-table entry
   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [TAG_W-1:0]  cur;
      logic [TAG_W-1:0]  newest;
   } ord_word_type;

endpackage
`default_nettype wire

>>> sv/rpq_req_if.sv
// Request channel of the read-priority queue block.
// Depends on rpq_pkg.
`default_nettype none
interface rpq_req_if;
   import rpq_pkg::*;
   logic                valid;
   logic                ready;
   logic [MODE_W-1:0]   mode;
   logic [QID_W-1:0]    queue_id;
   logic [ADDR_W-1:0]   lpa;
   logic                is_write;
   logic [HANDLE_W-1:0] request;
   logic [SLOT_W-1:0]   slot;

   modport source (output valid, mode, queue_id, lpa, is_write, request, slot,
                   input ready);
   modport sink (input valid, mode, queue_id, lpa, is_write, request, slot,
                 output ready);
endinterface
`default_nettype wire

>>> sv/rpq_rsp_if.sv
// Response channel of the read-priority queue block.
// Depends on rpq_pkg.
`default_nettype none
interface rpq_rsp_if;
   import rpq_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [SLOT_W-1:0]   slot_out;
   logic [HANDLE_W-1:0] request_out;
   logic [TAG_W-1:0]    tag_out;
   logic [COUNT_W-1:0]  count_out;
   logic                full_flag;
   logic                all_empty_flag;
   logic                head_ready;

   modport source (output valid, status, slot_out, request_out, tag_out, count_out,
                   full_flag, all_empty_flag, head_ready, input ready);
   modport sink (input valid, status, slot_out, request_out, tag_out, count_out,
                 full_flag, all_empty_flag, head_ready, output ready);
endinterface
`default_nettype wire

>>> sv/rpq_ram.sv
// Generic single-write, single-read RAM with registered, enabled read.
// No dependencies.
`default_nettype none
module rpq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end
endmodule
`default_nettype wire

>>> sv/rpq_tag_unit.sv
// Shared tag/address comparator and tag incrementer.
// Depends on rpq_pkg.
`default_nettype none
module rpq_tag_unit (
   input  wire logic [rpq_pkg::TAG_W-1:0] op_a,
   input  wire logic [rpq_pkg::TAG_W-1:0] op_b,
   output      logic                      eq,
   output      logic [rpq_pkg::TAG_W-1:0] inc
);
   import rpq_pkg::*;
   assign eq  = (op_a == op_b);
   assign inc = op_a + TAG_W'(1);   // wraps modulo 2^32
endmodule
`default_nettype wire

>>> sv/read_priority_io_queue_unit.sv
// Read-priority request queues over one shared item store, with per-address ordering tags.
// Enqueue scans the whole address table, one entry at a time, then writes; dequeue
// walks the queue from its head until an eligible read is found or the walk runs off
// the tail; remove and move read the item and its links, then relink; probe only checks.
// One request in flight; a finished response may wait while the next request is taken.
// Reset (synchronous, active high) clears valid bits, queue pointers, count and
// config registers; no clearing pass over the RAMs.
// Depends on rpq_pkg, rpq_req_if, rpq_rsp_if, rpq_ram and rpq_tag_unit.
`default_nettype none
module read_priority_io_queue_unit #(
   parameter int CAPACITY   = rpq_pkg::DEF_CAPACITY,
   parameter int NUM_QUEUES = rpq_pkg::DEF_NUM_QUEUES
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   rpq_req_if.sink                             req_bus,
   rpq_rsp_if.source                           rsp_bus,
   input  wire logic                           csr_we,
   input  wire logic [rpq_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [rpq_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import rpq_pkg::*;

   localparam int IW  = $clog2(CAPACITY);           // slot / entry index
   localparam int PW  = $clog2(CAPACITY + 1);       // index plus empty marker
   localparam int CW  = $clog2(CAPACITY + 1);       // item count
   localparam int QW  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int ITW = HANDLE_W + TAG_W + 1 + IW + QW;
   localparam int OWW = $bits(ord_word_type);
   localparam logic [PW-1:0] NIL = PW'(CAPACITY);

   // item word layout, low to high: handle, tag, write, entry, queue
   localparam int TAG_LO = HANDLE_W;
   localparam int WR_BIT = HANDLE_W + TAG_W;
   localparam int ENT_LO = WR_BIT + 1;
   localparam int Q_LO   = ENT_LO + IW;

   typedef enum logic [4:0] {
      S_IDLE, S_DEC,
      S_SC_RD, S_SC_CK, S_EN_W1, S_EN_W2,
      S_DQ_RD, S_DQ_OR, S_DQ_CK, S_DQ_END,
      S_RM_RD, S_RM_OR, S_RM_UP,
      S_MV_RD, S_MV_UL, S_MV_L1, S_MV_L2,
      S_FIN
   } state_type;

   state_type state_ff, state_in;

   // latched request
   logic [MODE_W-1:0]   mode_ff, mode_in;
   logic [QID_W-1:0]    qid_ff, qid_in;
   logic [ADDR_W-1:0]   lpa_ff, lpa_in;
   logic                wr_ff, wr_in;
   logic [HANDLE_W-1:0] hnd_ff, hnd_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;

   // config
   logic [QC_W-1:0] qc_ff, qc_in;
   logic [CL_W-1:0] cl_ff, cl_in;

   // flop-held state: valid and lock bits, queue pointers, count
   logic [CAPACITY-1:0] ivalid_ff, ivalid_in;
   logic [CAPACITY-1:0] ovalid_ff, ovalid_in;
   logic [CAPACITY-1:0] locked_ff, locked_in;
   logic [PW-1:0]       head_ff [NUM_QUEUES];
   logic [PW-1:0]       head_in [NUM_QUEUES];
   logic [PW-1:0]       tail_ff [NUM_QUEUES];
   logic [PW-1:0]       tail_in [NUM_QUEUES];
   logic [CW-1:0]       count_ff, count_in;

   // sequencer working registers
   logic [IW-1:0]     idx_ff, idx_in;          // address-table scan
   logic [PW-1:0]     e_ff, e_in;              // matching entry
   logic [PW-1:0]     fe_ff, fe_in;            // first free entry
   logic [PW-1:0]     s_ff, s_in;              // first free slot
   logic [TAG_W-1:0]  ecur_ff, ecur_in;
   logic [TAG_W-1:0]  enew_ff, enew_in;
   logic [PW-1:0]     cur_ff, cur_in;          // dequeue walk
   logic [CW-1:0]     steps_ff, steps_in;
   logic [PW-1:0]     pick_ff, pick_in;
   logic [HANDLE_W-1:0] pickh_ff, pickh_in;

   // response being built, and the response register
   logic [STATUS_W-1:0] st_ff, st_in;
   logic [IW-1:0]       so_ff, so_in;
   logic [HANDLE_W-1:0] ro_ff, ro_in;
   logic [TAG_W-1:0]    to_ff, to_in;

   logic                rv_ff, rv_in;
   logic [STATUS_W-1:0] rst_ff, rst_in;
   logic [SLOT_W-1:0]   rslot_ff, rslot_in;
   logic [HANDLE_W-1:0] rreq_ff, rreq_in;
   logic [TAG_W-1:0]    rtag_ff, rtag_in;
   logic [COUNT_W-1:0]  rcnt_ff, rcnt_in;
   logic                rfull_ff, rfull_in;
   logic                rempty_ff, rempty_in;
   logic                rhead_ff, rhead_in;

   // RAM ports
   logic          it_we, it_re;
   logic [IW-1:0] it_wa, it_ra;
   logic [ITW-1:0] it_wd, it_rd;
   logic          or_we, or_re;
   logic [IW-1:0] or_wa, or_ra;
   ord_word_type  or_wd, or_rd;
   logic          nx_we, pv_we, lk_re;
   logic [IW-1:0] nx_wa, pv_wa, lk_ra;
   logic [PW-1:0] nx_wd, pv_wd, nx_rd, pv_rd;

   // shared compare / increment unit
   logic [TAG_W-1:0] op_a, op_b, tag_inc;
   logic             tag_eq;

   // item word fields
   logic [QW-1:0]       it_queue;
   logic [IW-1:0]       it_entry;
   logic                it_wr;
   logic [TAG_W-1:0]    it_tag;
   logic [HANDLE_W-1:0] it_handle;

   assign it_queue  = it_rd[Q_LO +: QW];
   assign it_entry  = it_rd[ENT_LO +: IW];
   assign it_wr     = it_rd[WR_BIT];
   assign it_tag    = it_rd[TAG_LO +: TAG_W];
   assign it_handle = it_rd[HANDLE_W-1:0];

   rpq_ram #(.WIDTH(ITW), .DEPTH(CAPACITY)) u_item_ram (
      .clock(clock), .we(it_we), .waddr(it_wa), .wdata(it_wd),
      .re(it_re), .raddr(it_ra), .rdata(it_rd));

   rpq_ram #(.WIDTH(OWW), .DEPTH(CAPACITY)) u_order_ram (
      .clock(clock), .we(or_we), .waddr(or_wa), .wdata(or_wd),
      .re(or_re), .raddr(or_ra), .rdata(or_rd));

   rpq_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_next_ram (
      .clock(clock), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd),
      .re(lk_re), .raddr(lk_ra), .rdata(nx_rd));

   rpq_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_prev_ram (
      .clock(clock), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd),
      .re(lk_re), .raddr(lk_ra), .rdata(pv_rd));

   rpq_tag_unit u_tag (.op_a(op_a), .op_b(op_b), .eq(tag_eq), .inc(tag_inc));

   // decoded helpers
   logic [QW-1:0] qidx;
   logic [IW-1:0] sidx;
   logic          queue_ok, slot_ok;
   logic [CW-1:0] eff_limit;
   logic [PW-1:0] head_q;
   logic [PW-1:0] eidx;

   assign qidx      = QW'(qid_ff);
   assign sidx      = IW'(slot_ff);
   assign queue_ok  = (32'(qid_ff) < 32'(qc_ff)) && (32'(qid_ff) < NUM_QUEUES);
   assign slot_ok   = (32'(slot_ff) < CAPACITY) && ivalid_ff[sidx];
   assign eff_limit = (cl_ff == '0 || 32'(cl_ff) > CAPACITY) ? CW'(CAPACITY) : CW'(cl_ff);
   assign head_q    = head_ff[qidx];
   assign eidx      = (e_ff != NIL) ? e_ff : fe_ff;

   assign req_bus.ready          = (state_ff == S_IDLE);
   assign rsp_bus.valid          = rv_ff;
   assign rsp_bus.status         = rst_ff;
   assign rsp_bus.slot_out       = rslot_ff;
   assign rsp_bus.request_out    = rreq_ff;
   assign rsp_bus.tag_out        = rtag_ff;
   assign rsp_bus.count_out      = rcnt_ff;
   assign rsp_bus.full_flag      = rfull_ff;
   assign rsp_bus.all_empty_flag = rempty_ff;
   assign rsp_bus.head_ready     = rhead_ff;

   always_comb begin
      state_in = state_ff;
      mode_in = mode_ff; qid_in = qid_ff; lpa_in = lpa_ff;
      wr_in = wr_ff; hnd_in = hnd_ff; slot_in = slot_ff;
      qc_in = qc_ff; cl_in = cl_ff;
      ivalid_in = ivalid_ff; ovalid_in = ovalid_ff; locked_in = locked_ff;
      head_in = head_ff; tail_in = tail_ff; count_in = count_ff;
      idx_in = idx_ff; e_in = e_ff; fe_in = fe_ff; s_in = s_ff;
      ecur_in = ecur_ff; enew_in = enew_ff;
      cur_in = cur_ff; steps_in = steps_ff; pick_in = pick_ff; pickh_in = pickh_ff;
      st_in = st_ff; so_in = so_ff; ro_in = ro_ff; to_in = to_ff;
      rv_in = rv_ff; rst_in = rst_ff; rslot_in = rslot_ff; rreq_in = rreq_ff;
      rtag_in = rtag_ff; rcnt_in = rcnt_ff; rfull_in = rfull_ff;
      rempty_in = rempty_ff; rhead_in = rhead_ff;

      it_we = 1'b0; it_wa = '0; it_wd = '0; it_re = 1'b0; it_ra = '0;
      or_we = 1'b0; or_wa = '0; or_wd = '0; or_re = 1'b0; or_ra = '0;
      nx_we = 1'b0; nx_wa = '0; nx_wd = '0;
      pv_we = 1'b0; pv_wa = '0; pv_wd = '0;
      lk_re = 1'b0; lk_ra = '0;
      op_a = or_rd.addr; op_b = lpa_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_QUEUE_COUNT:    qc_in = QC_W'(csr_wdata);
            CSR_CAPACITY_LIMIT: cl_in = CL_W'(csr_wdata);
            default: ;
         endcase
      end

      if (rv_ff && rsp_bus.ready) begin
         rv_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               mode_in  = req_bus.mode;
               qid_in   = req_bus.queue_id;
               lpa_in   = req_bus.lpa;
               wr_in    = req_bus.is_write;
               hnd_in   = req_bus.request;
               slot_in  = req_bus.slot;
               state_in = S_DEC;
            end
         end

         S_DEC: begin
            st_in = ST_OK; so_in = '0; ro_in = '0; to_in = '0;
            state_in = S_FIN;
            case (mode_ff)
               MODE_ENQUEUE: begin
                  if (!queue_ok) begin
                     st_in = ST_BADQ;
                  end else if (count_ff >= eff_limit) begin
                     st_in = ST_FULL;
                  end else begin
                     idx_in = '0; e_in = NIL; fe_in = NIL; s_in = NIL;
                     state_in = S_SC_RD;
                  end
               end
               MODE_DEQUEUE: begin
                  if (!queue_ok) begin
                     st_in = ST_BADQ;
                  end else begin
                     cur_in = head_q; steps_in = '0; pick_in = NIL;
                     state_in = S_DQ_RD;
                  end
               end
               MODE_REMOVE: begin
                  if (!slot_ok) st_in = ST_BADSLOT;
                  else          state_in = S_RM_RD;
               end
               MODE_MOVE: begin
                  if (!queue_ok)     st_in = ST_BADQ;
                  else if (!slot_ok) st_in = ST_BADSLOT;
                  else               state_in = S_MV_RD;
               end
               default: begin   // probe and unused codes
                  if (!queue_ok) st_in = ST_BADQ;
               end
            endcase
         end

         // address-table scan: first match, first free entry, first free slot
         S_SC_RD: begin
            or_re = 1'b1; or_ra = idx_ff;
            state_in = S_SC_CK;
         end
         S_SC_CK: begin
            op_a = or_rd.addr; op_b = lpa_ff;
            if (e_ff == NIL && ovalid_ff[idx_ff] && tag_eq) begin
               e_in = PW'(idx_ff); ecur_in = or_rd.cur; enew_in = or_rd.newest;
            end
            if (fe_ff == NIL && !ovalid_ff[idx_ff]) fe_in = PW'(idx_ff);
            if (s_ff == NIL && !ivalid_ff[idx_ff])  s_in = PW'(idx_ff);
            if (idx_ff == IW'(CAPACITY - 1)) begin
               state_in = S_EN_W1;
            end else begin
               idx_in = idx_ff + IW'(1);
               state_in = S_SC_RD;
            end
         end
         S_EN_W1: begin
            op_a = enew_ff;
            if (s_ff == NIL || eidx == NIL) begin
               st_in = ST_FULL;
               state_in = S_FIN;
            end else begin
               or_we = 1'b1; or_wa = eidx[IW-1:0];
               or_wd.addr   = lpa_ff;
               or_wd.cur    = (e_ff != NIL) ? ecur_ff : TAG_W'(1);
               or_wd.newest = (e_ff != NIL) ? tag_inc : TAG_W'(1);
               ovalid_in[eidx[IW-1:0]] = 1'b1;
               it_we = 1'b1; it_wa = s_ff[IW-1:0];
               it_wd = {qidx, eidx[IW-1:0], wr_ff, or_wd.newest, hnd_ff};
               nx_we = 1'b1; nx_wa = s_ff[IW-1:0]; nx_wd = NIL;
               pv_we = 1'b1; pv_wa = s_ff[IW-1:0]; pv_wd = tail_ff[qidx];
               to_in = or_wd.newest;
               so_in = s_ff[IW-1:0];
               state_in = S_EN_W2;
            end
         end
         S_EN_W2: begin
            if (tail_ff[qidx] != NIL) begin
               nx_we = 1'b1; nx_wa = tail_ff[qidx][IW-1:0]; nx_wd = s_ff;
            end else begin
               head_in[qidx] = s_ff;
            end
            tail_in[qidx] = s_ff;
            ivalid_in[s_ff[IW-1:0]] = 1'b1;
            locked_in[s_ff[IW-1:0]] = 1'b0;
            count_in = count_ff + CW'(1);
            state_in = S_FIN;
         end

         // dequeue walk: item word, then its address entry, then check
         S_DQ_RD: begin
            if (cur_ff == NIL || steps_ff == CW'(CAPACITY)) begin
               state_in = S_DQ_END;
            end else begin
               it_re = 1'b1; it_ra = cur_ff[IW-1:0];
               lk_re = 1'b1; lk_ra = cur_ff[IW-1:0];
               state_in = S_DQ_OR;
            end
         end
         S_DQ_OR: begin
            or_re = 1'b1; or_ra = it_entry;
            state_in = S_DQ_CK;
         end
         S_DQ_CK: begin
            op_a = or_rd.cur; op_b = it_tag;
            if (!locked_ff[cur_ff[IW-1:0]] && ovalid_ff[it_entry] && tag_eq &&
                (!it_wr || pick_ff == NIL)) begin
               pick_in = cur_ff; pickh_in = it_handle;
            end
            if (!locked_ff[cur_ff[IW-1:0]] && ovalid_ff[it_entry] && tag_eq && !it_wr) begin
               state_in = S_DQ_END;   // first eligible read wins
            end else begin
               cur_in = nx_rd;
               steps_in = steps_ff + CW'(1);
               state_in = S_DQ_RD;
            end
         end
         S_DQ_END: begin
            if (pick_ff == NIL) begin
               st_in = ST_NONE;
            end else begin
               locked_in[pick_ff[IW-1:0]] = 1'b1;
               so_in = pick_ff[IW-1:0];
               ro_in = pickh_ff;
            end
            state_in = S_FIN;
         end

         // remove: advance or free the address entry, unlink the item
         S_RM_RD: begin
            it_re = 1'b1; it_ra = sidx;
            lk_re = 1'b1; lk_ra = sidx;
            state_in = S_RM_OR;
         end
         S_RM_OR: begin
            or_re = 1'b1; or_ra = it_entry;
            state_in = S_RM_UP;
         end
         S_RM_UP: begin
            op_a = or_rd.cur; op_b = or_rd.newest;
            if (ovalid_ff[it_entry]) begin
               if (tag_eq) begin
                  ovalid_in[it_entry] = 1'b0;
               end else begin
                  or_we = 1'b1; or_wa = it_entry;
                  or_wd = or_rd;
                  or_wd.cur = tag_inc;
               end
            end
            if (pv_rd != NIL) begin
               nx_we = 1'b1; nx_wa = pv_rd[IW-1:0]; nx_wd = nx_rd;
            end else begin
               head_in[it_queue] = nx_rd;
            end
            if (nx_rd != NIL) begin
               pv_we = 1'b1; pv_wa = nx_rd[IW-1:0]; pv_wd = pv_rd;
            end else begin
               tail_in[it_queue] = pv_rd;
            end
            ivalid_in[sidx] = 1'b0;
            locked_in[sidx] = 1'b0;
            if (count_ff != '0) count_in = count_ff - CW'(1);
            state_in = S_FIN;
         end

         // move to head: unlink, then link at the head of the named queue
         S_MV_RD: begin
            it_re = 1'b1; it_ra = sidx;
            lk_re = 1'b1; lk_ra = sidx;
            state_in = S_MV_UL;
         end
         S_MV_UL: begin
            if (pv_rd != NIL) begin
               nx_we = 1'b1; nx_wa = pv_rd[IW-1:0]; nx_wd = nx_rd;
            end else begin
               head_in[it_queue] = nx_rd;
            end
            if (nx_rd != NIL) begin
               pv_we = 1'b1; pv_wa = nx_rd[IW-1:0]; pv_wd = pv_rd;
            end else begin
               tail_in[it_queue] = pv_rd;
            end
            locked_in[sidx] = 1'b0;
            state_in = S_MV_L1;
         end
         S_MV_L1: begin
            pv_we = 1'b1; pv_wa = sidx; pv_wd = NIL;
            nx_we = 1'b1; nx_wa = sidx; nx_wd = head_q;
            it_we = 1'b1; it_wa = sidx;
            it_wd = {qidx, it_rd[Q_LO-1:0]};
            state_in = S_MV_L2;
         end
         S_MV_L2: begin
            if (head_q != NIL) begin
               pv_we = 1'b1; pv_wa = head_q[IW-1:0]; pv_wd = PW'(sidx);
            end else begin
               tail_in[qidx] = PW'(sidx);
            end
            head_in[qidx] = PW'(sidx);
            state_in = S_FIN;
         end

         // load the response once the previous one has been taken
         S_FIN: begin
            if (!rv_ff || rsp_bus.ready) begin
               rv_in     = 1'b1;
               rst_in    = st_ff;
               rslot_in  = SLOT_W'(so_ff);
               rreq_in   = ro_ff;
               rtag_in   = to_ff;
               rcnt_in   = COUNT_W'(count_ff);
               rfull_in  = (count_ff == eff_limit);
               rempty_in = (count_ff == '0);
               rhead_in  = queue_ok && (head_q != NIL) && !locked_ff[head_q[IW-1:0]];
               state_in  = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         qc_ff     <= QUEUE_COUNT_RESET;
         cl_ff     <= CAP_LIMIT_RESET;
         ivalid_ff <= '0;
         ovalid_ff <= '0;
         count_ff  <= '0;
         rv_ff     <= 1'b0;
         for (int q = 0; q < NUM_QUEUES; q++) begin
            head_ff[q] <= NIL;
            tail_ff[q] <= NIL;
         end
      end else begin
         state_ff  <= state_in;
         qc_ff     <= qc_in;
         cl_ff     <= cl_in;
         ivalid_ff <= ivalid_in;
         ovalid_ff <= ovalid_in;
         count_ff  <= count_in;
         rv_ff     <= rv_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
      end
      mode_ff <= mode_in; qid_ff <= qid_in; lpa_ff <= lpa_in;
      wr_ff <= wr_in; hnd_ff <= hnd_in; slot_ff <= slot_in;
      locked_ff <= locked_in;
      idx_ff <= idx_in; e_ff <= e_in; fe_ff <= fe_in; s_ff <= s_in;
      ecur_ff <= ecur_in; enew_ff <= enew_in;
      cur_ff <= cur_in; steps_ff <= steps_in; pick_ff <= pick_in; pickh_ff <= pickh_in;
      st_ff <= st_in; so_ff <= so_in; ro_ff <= ro_in; to_ff <= to_in;
      rst_ff <= rst_in; rslot_ff <= rslot_in; rreq_ff <= rreq_in; rtag_ff <= rtag_in;
      rcnt_ff <= rcnt_in; rfull_ff <= rfull_in; rempty_ff <= rempty_in;
      rhead_ff <= rhead_in;
   end
endmodule
`default_nettype wire

>>> sim/rpq_queue_checker.sv
// Checker for the read-priority queue block: keeps its own copy of the queues, items and
// address tags, predicts each response and compares it with what the block returns.
// Depends on rpq_pkg, rpq_req_if and rpq_rsp_if.
`default_nettype none
module rpq_queue_checker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   rpq_req_if                                  req,
   rpq_rsp_if                                  rsp,
   input  wire logic                           csr_we,
   input  wire logic [rpq_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [rpq_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                                  fail_count,
   output int                                  pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import rpq_pkg::*;

   localparam int SLOTS = DEF_CAPACITY;
   localparam int QUEUES = DEF_NUM_QUEUES;
   localparam int NIL = SLOTS;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot_out;
      logic [HANDLE_W-1:0] request_out;
      logic [TAG_W-1:0]    tag_out;
      logic [COUNT_W-1:0]  count_out;
      logic                full_flag;
      logic                all_empty_flag;
      logic                head_ready;
   } queue_rsp_t;

   // item store
   logic                item_live[SLOTS];
   logic [QID_W-1:0]    item_qid[SLOTS];
   logic [ADDR_W-1:0]   item_lpa[SLOTS];
   logic [TAG_W-1:0]    item_seq[SLOTS];
   logic                item_lock[SLOTS];
   logic                item_wr[SLOTS];
   logic [HANDLE_W-1:0] item_req[SLOTS];
   int                  item_nxt[SLOTS];
   int                  item_prv[SLOTS];
   int                  q_first[QUEUES];
   int                  q_last[QUEUES];
   // address tag table
   logic                tag_live[SLOTS];
   logic [ADDR_W-1:0]   tag_lpa[SLOTS];
   logic [TAG_W-1:0]    tag_cur[SLOTS];
   logic [TAG_W-1:0]    tag_new[SLOTS];
   int                  held;
   logic [QC_W-1:0]     queues_used;
   logic [CL_W-1:0]     cap_limit;

   queue_rsp_t expected_rsps[$];

   function automatic int limit_now();
      return (cap_limit == 0 || cap_limit > SLOTS) ? SLOTS : int'(cap_limit);
   endfunction

   function automatic bit queue_good(logic [QID_W-1:0] q);
      return q < queues_used && q < QUEUES;
   endfunction

   function automatic int tag_entry(logic [ADDR_W-1:0] a);
      for (int i = 0; i < SLOTS; i++)
         if (tag_live[i] && tag_lpa[i] == a) return i;
      return NIL;
   endfunction

   function automatic void unlink_slot(int s);
      int p, n;
      p = item_prv[s];
      n = item_nxt[s];
      if (p < SLOTS) item_nxt[p] = n; else q_first[item_qid[s]] = n;
      if (n < SLOTS) item_prv[n] = p; else q_last[item_qid[s]] = p;
      item_nxt[s] = NIL;
      item_prv[s] = NIL;
   endfunction

   function automatic void clear_model();
      for (int i = 0; i < SLOTS; i++) begin
         item_live[i] = 0; item_qid[i] = '0; item_lpa[i] = '0; item_seq[i] = '0;
         item_lock[i] = 0; item_wr[i] = 0; item_req[i] = '0;
         item_nxt[i] = NIL; item_prv[i] = NIL;
         tag_live[i] = 0; tag_lpa[i] = '0; tag_cur[i] = '0; tag_new[i] = '0;
      end
      for (int q = 0; q < QUEUES; q++) begin
         q_first[q] = NIL;
         q_last[q] = NIL;
      end
      held = 0;
      queues_used = QUEUE_COUNT_RESET;
      cap_limit = CAP_LIMIT_RESET;
   endfunction

   function automatic queue_rsp_t apply_request(logic [MODE_W-1:0] m, logic [QID_W-1:0] q,
                                                logic [ADDR_W-1:0] a, logic w,
                                                logic [HANDLE_W-1:0] h, logic [SLOT_W-1:0] s);
      queue_rsp_t r;
      int free_s, e, pick, cur, steps, hd;
      r = '0;
      r.status = ST_OK;
      case (m)
         MODE_ENQUEUE: begin
            if (!queue_good(q)) r.status = ST_BADQ;
            else if (held >= limit_now()) r.status = ST_FULL;
            else begin
               free_s = NIL;
               for (int i = 0; i < SLOTS; i++)
                  if (!item_live[i]) begin free_s = i; break; end
               e = tag_entry(a);
               if (e == NIL)
                  for (int i = 0; i < SLOTS; i++)
                     if (!tag_live[i]) begin e = i; break; end
               if (free_s == NIL || e == NIL) r.status = ST_FULL;
               else begin
                  if (tag_live[e] && tag_lpa[e] == a) tag_new[e] = tag_new[e] + TAG_W'(1);
                  else begin
                     tag_live[e] = 1; tag_lpa[e] = a;
                     tag_cur[e] = TAG_W'(1); tag_new[e] = TAG_W'(1);
                  end
                  item_live[free_s] = 1;
                  item_lpa[free_s] = a;
                  item_seq[free_s] = tag_new[e];
                  item_lock[free_s] = 0;
                  item_wr[free_s] = w;
                  item_req[free_s] = h;
                  // append at tail
                  item_qid[free_s] = q;
                  item_nxt[free_s] = NIL;
                  item_prv[free_s] = q_last[q];
                  if (q_last[q] < SLOTS) item_nxt[q_last[q]] = free_s;
                  else q_first[q] = free_s;
                  q_last[q] = free_s;
                  held++;
                  r.slot_out = SLOT_W'(free_s);
                  r.tag_out = item_seq[free_s];
               end
            end
         end
         MODE_DEQUEUE: begin
            if (!queue_good(q)) r.status = ST_BADQ;
            else begin
               pick = NIL;
               cur = q_first[q];
               steps = 0;
               // first eligible read wins, else first eligible write
               while (cur < SLOTS && steps < SLOTS) begin
                  if (!item_lock[cur]) begin
                     e = tag_entry(item_lpa[cur]);
                     if (e != NIL && tag_cur[e] == item_seq[cur]) begin
                        if (!item_wr[cur]) begin pick = cur; break; end
                        if (pick == NIL) pick = cur;
                     end
                  end
                  cur = item_nxt[cur];
                  steps++;
               end
               if (pick == NIL) r.status = ST_NONE;
               else begin
                  item_lock[pick] = 1;
                  r.slot_out = SLOT_W'(pick);
                  r.request_out = item_req[pick];
               end
            end
         end
         MODE_REMOVE: begin
            if (!item_live[s]) r.status = ST_BADSLOT;
            else begin
               e = tag_entry(item_lpa[s]);
               if (e != NIL) begin
                  if (tag_new[e] == tag_cur[e]) tag_live[e] = 0;
                  else tag_cur[e] = tag_cur[e] + TAG_W'(1);
               end
               unlink_slot(s);
               item_live[s] = 0;
               item_lock[s] = 0;
               if (held > 0) held--;
            end
         end
         MODE_MOVE: begin
            if (!queue_good(q)) r.status = ST_BADQ;
            else if (!item_live[s]) r.status = ST_BADSLOT;
            else begin
               unlink_slot(s);
               item_lock[s] = 0;
               item_qid[s] = q;
               item_prv[s] = NIL;
               item_nxt[s] = q_first[q];
               if (q_first[q] < SLOTS) item_prv[q_first[q]] = s; else q_last[q] = s;
               q_first[q] = s;
            end
         end
         default: if (!queue_good(q)) r.status = ST_BADQ;  // probe and unknown modes
      endcase
      r.count_out = COUNT_W'(held);
      r.full_flag = (held == limit_now());
      r.all_empty_flag = (held == 0);
      hd = queue_good(q) ? q_first[q] : NIL;
      r.head_ready = (hd < SLOTS) && !item_lock[hd];
      return r;
   endfunction

   always @(posedge clock) begin
      queue_rsp_t want, got;
      if (reset) begin
         clear_model();
         expected_rsps.delete();
         fail_count = 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            got = '{rsp.status, rsp.slot_out, rsp.request_out, rsp.tag_out, rsp.count_out,
                    rsp.full_flag, rsp.all_empty_flag, rsp.head_ready};
            if (expected_rsps.size() == 0) begin
               fail_count++;
               $display("%0t: response with nothing expected: %p", $realtime, got);
            end else begin
               want = expected_rsps.pop_front();
               if (got !== want) begin
                  fail_count++;
                  $display("%0t: response mismatch\n  expected %p\n  actual   %p",
                           $realtime, want, got);
               end
            end
         end
         if (req.valid && req.ready)
            expected_rsps.push_back(apply_request(req.mode, req.queue_id, req.lpa,
                                                  req.is_write, req.request, req.slot));
         if (csr_we) begin
            if (csr_index == CSR_QUEUE_COUNT) queues_used = csr_wdata[QC_W-1:0];
            else if (csr_index == CSR_CAPACITY_LIMIT) cap_limit = csr_wdata[CL_W-1:0];
         end
      end
      pending_count = expected_rsps.size();
   end
endmodule
`default_nettype wire

>>> sim/tb.sv
// Top of the read-priority queue testbench: clock, reset, request stimulus, response
// back-pressure, register phases and the verdict. Depends on rpq_pkg, both channel
// interfaces, read_priority_io_queue_unit and rpq_queue_checker.
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rpq_pkg::*;

   localparam logic [MODE_W-1:0] MODE_PROBE = 3'd4;
   localparam logic [MODE_W-1:0] MODE_ODD_LO = 3'd5;  // 5..7 behave as probe
   localparam logic [MODE_W-1:0] MODE_ODD_HI = 3'd7;
   localparam int STALL_LIMIT = 4000;   // cycles with no request or response moving
   localparam int SETTLE = 2 * DEF_CAPACITY + 40;  // settling wait after the block drains, padded
   localparam int HOLD_OFF = 500;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    fail_count;
   int                    pending_count;
   int                    quiet_cycles;
   bit                    hold_rsp;   // set by stimulus; the response side holds off once
   bit                    calm;       // no gaps on the request side while set

   rpq_req_if req_bus ();
   rpq_rsp_if rsp_bus ();

   read_priority_io_queue_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   rpq_queue_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req           (req_bus),
      .rsp           (rsp_bus),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // watchdog: anything stuck for too long ends the run
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   // response side: mostly ready, short stalls, rare long ones, one long hold-off on request
   initial begin
      int pick;
      bit hold_done;
      hold_done = 0;
      rsp_bus.ready <= 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         pick = $urandom_range(0, 99);
         if (hold_rsp && !hold_done) begin
            rsp_bus.ready <= 0;
            repeat (HOLD_OFF) @(posedge clock);
            hold_done = 1;
         end else if (pick < 70) begin
            rsp_bus.ready <= 1;
            @(posedge clock);
         end else if (pick < 97) begin
            rsp_bus.ready <= 0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 0;
            repeat ($urandom_range(10, 40)) @(posedge clock);
         end
      end
   end

   function automatic int request_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (calm || pick < 55) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // offers one request and returns right after the edge that takes it
   task automatic send_request(input logic [MODE_W-1:0] m, input logic [QID_W-1:0] q,
                               input logic [ADDR_W-1:0] a, input logic w,
                               input logic [HANDLE_W-1:0] h, input logic [SLOT_W-1:0] s);
      int gap;
      logic taken;
      gap = request_gap();
      if (gap > 0) begin
         req_bus.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1;
      req_bus.mode <= m;
      req_bus.queue_id <= q;
      req_bus.lpa <= a;
      req_bus.is_write <= w;
      req_bus.request <= h;
      req_bus.slot <= s;
      do begin
         @(negedge clock);
         taken = req_bus.ready;
         @(posedge clock);
      end while (!taken);
   endtask

   // random request with most traffic on a few queues and addresses so tags chain up
   task automatic send_random();
      int pick;
      logic [MODE_W-1:0] m;
      logic [QID_W-1:0] q;
      logic [ADDR_W-1:0] a;
      logic [SLOT_W-1:0] s;
      logic w;
      pick = $urandom_range(0, 99);
      if (pick < 36) m = MODE_ENQUEUE;
      else if (pick < 62) m = MODE_DEQUEUE;
      else if (pick < 86) m = MODE_REMOVE;
      else if (pick < 94) m = MODE_MOVE;
      else if (pick < 97) m = MODE_PROBE;
      else m = MODE_W'($urandom_range(MODE_ODD_LO, MODE_ODD_HI));
      q = QID_W'(($urandom_range(0, 99) < 65) ? $urandom_range(0, 3) : $urandom_range(0, 15));
      a = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 7) : $urandom;
      // live slots sit low since free slots are taken lowest first
      s = SLOT_W'(($urandom_range(0, 99) < 85) ? $urandom_range(0, 24) : $urandom_range(0, 63));
      w = 1'($urandom_range(0, 1));
      send_request(m, q, a, w, $urandom, s);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] v);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 0;
   endtask

   // drains the block, then sets both registers for the next phase
   task automatic new_setting(input logic [CSR_DATA_W-1:0] qc, input logic [CSR_DATA_W-1:0] cl);
      req_bus.valid <= 0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_write(CSR_QUEUE_COUNT, qc);
      csr_write(CSR_CAPACITY_LIMIT, cl);
   endtask

   task automatic random_phase(input int n);
      for (int i = 0; i < n; i++) begin
         if (i % 100 == 0) calm = ($urandom_range(0, 3) == 0);
         send_random();
      end
      calm = 0;
   endtask

   initial begin
      int wait_cycles;
      reset <= 1;
      csr_we <= 0;
      csr_index <= '0;
      csr_wdata <= '0;
      req_bus.valid <= 0;
      req_bus.mode <= MODE_PROBE;
      req_bus.queue_id <= '0;
      req_bus.lpa <= '0;
      req_bus.is_write <= 0;
      req_bus.request <= '0;
      req_bus.slot <= '0;
      hold_rsp = 0;
      calm = 0;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: ordering on one address, read priority, locks, moves, bad slots
      send_request(MODE_PROBE, 0, 0, 0, 0, 0);
      send_request(MODE_ENQUEUE, 0, 32'h0, 0, 32'h0, 0);           // slot 0, tag 1
      send_request(MODE_ENQUEUE, 0, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 0);
      send_request(MODE_ENQUEUE, 15, 32'h0, 0, 32'h1234_5678, 0);  // same address, tag 2
      send_request(MODE_ENQUEUE, 0, 32'h0, 1, 32'hA5A5_5A5A, 0);   // tag 3
      send_request(MODE_DEQUEUE, 0, 0, 0, 0, 0);   // read beats write
      send_request(MODE_DEQUEUE, 0, 0, 0, 0, 0);   // then the write
      send_request(MODE_DEQUEUE, 0, 0, 0, 0, 0);   // nothing eligible
      send_request(MODE_DEQUEUE, 15, 0, 0, 0, 0);  // tag not yet current
      send_request(MODE_REMOVE, 0, 0, 0, 0, 6'd0); // advances the address tag
      send_request(MODE_DEQUEUE, 15, 0, 0, 0, 0);
      send_request(MODE_MOVE, 3, 0, 0, 0, 6'd2);   // unlock and move to head
      send_request(MODE_PROBE, 3, 0, 0, 0, 0);
      send_request(MODE_REMOVE, 0, 0, 0, 0, 6'd63);
      send_request(MODE_MOVE, 1, 0, 0, 0, 6'd40);
      send_request(MODE_REMOVE, 0, 0, 0, 0, 6'd1); // frees that address entry
      send_request(MODE_ODD_LO, 2, 0, 0, 0, 0);
      send_request(MODE_ODD_HI, 15, 0, 0, 0, 0);
      send_request(MODE_REMOVE, 0, 0, 0, 0, 6'd2);
      send_request(MODE_REMOVE, 0, 0, 0, 0, 6'd3);

      // defaults rewritten, with the response side held off to back up the input
      new_setting(16, 64);
      random_phase(60);
      hold_rsp = 1;
      random_phase(330);
      // one queue, one item
      new_setting(1, 1);
      send_request(MODE_ENQUEUE, 1, 0, 0, 0, 0);   // bad queue
      random_phase(60);
      // zero queues in use, zero limit meaning the whole store
      new_setting(0, 0);
      random_phase(40);
      // widest values: limit above the store size
      new_setting(31, 127);
      random_phase(250);
      new_setting(3, 5);
      random_phase(150);
      new_setting(16, 64);
      random_phase(250);

      req_bus.valid <= 0;
      wait_cycles = 0;
      @(negedge clock);
      while (pending_count != 0 && wait_cycles < 20 * STALL_LIMIT) begin
         @(negedge clock);
         wait_cycles++;
      end
      repeat (SETTLE) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end
endmodule
`default_nettype wire

>>> read_priority_io_queue_unit.f
sv/rpq_pkg.sv
sv/rpq_req_if.sv
sv/rpq_rsp_if.sv
sv/rpq_ram.sv
sv/rpq_tag_unit.sv
sv/read_priority_io_queue_unit.sv
sim/rpq_queue_checker.sv
sim/tb.sv
